// File: rtl/core/ezlr_pkg.sv
package ezlr_pkg;

	localparam int CoordBitsDefault = 11;

	localparam logic OpStart = 1'b0;
	localparam logic OpStep  = 1'b1;

	localparam logic [2:0] Zone0 = 3'd0;
	localparam logic [2:0] Zone1 = 3'd1;
	localparam logic [2:0] Zone2 = 3'd2;
	localparam logic [2:0] Zone3 = 3'd3;
	localparam logic [2:0] Zone4 = 3'd4;
	localparam logic [2:0] Zone5 = 3'd5;
	localparam logic [2:0] Zone6 = 3'd6;
	localparam logic [2:0] Zone7 = 3'd7;

	// control part of a classified command word
	typedef struct packed {
		logic       op;
		logic [2:0] zone;
		logic [1:0] color;
	} cmd_ctl_t;

	localparam int CmdCtlBits = $bits(cmd_ctl_t);

	// control part of a result word
	typedef struct packed {
		logic       valid;
		logic [2:0] zone;
		logic [1:0] color;
		logic       last;
	} res_ctl_t;

	localparam int ResCtlBits = $bits(res_ctl_t);

endpackage

// File: rtl/core/ezlr_queue.sv
module ezlr_queue #(
	parameter int DATA_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  logic [DATA_BITS-1:0] wdata,
	output logic                 full,
	input  logic                 rd,
	output logic [DATA_BITS-1:0] rdata,
	output logic                 empty
);

	logic [DATA_BITS-1:0] mem_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr)
				wr_ptr_q <= !wr_ptr_q;
			if (do_rd)
				rd_ptr_q <= !rd_ptr_q;
			if (do_wr && !do_rd)
				count_q <= count_q + 2'd1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

// File: rtl/core/ezlr_front.sv
module ezlr_front #(
	parameter int COORD_BITS = ezlr_pkg::CoordBitsDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     operation,
	input  logic [COORD_BITS-1:0]    start_x,
	input  logic [COORD_BITS-1:0]    start_y,
	input  logic [COORD_BITS-1:0]    end_x,
	input  logic [COORD_BITS-1:0]    end_y,
	input  logic [1:0]               color_index,
	output logic                     cmd_wr,
	input  logic                     cmd_full,
	output ezlr_pkg::cmd_ctl_t       cmd_ctl,
	output logic [COORD_BITS:0]      cmd_a0,
	output logic [COORD_BITS:0]      cmd_b0,
	output logic [COORD_BITS-1:0]    cmd_ddx,
	output logic [COORD_BITS-1:0]    cmd_ddy
);

	localparam int W = COORD_BITS;

	logic          valid_s1;
	logic          op_s1;
	logic [1:0]    color_s1;
	logic [W:0]    x0_s1;
	logic [W:0]    y0_s1;
	logic [W:0]    dx_s1;
	logic [W:0]    dy_s1;
	logic          take;

	logic [W+1:0]  sum;
	logic [W+1:0]  diff;
	logic [2:0]    zone;
	logic [W:0]    nx0;
	logic [W:0]    ny0;
	logic [W:0]    ndx;
	logic [W:0]    ndy;
	logic [W:0]    ddx_w;
	logic [W:0]    ddy_w;

	assign full   = valid_s1 && cmd_full;
	assign take   = push && !full;
	assign cmd_wr = valid_s1 && !cmd_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!cmd_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1    <= operation;
			color_s1 <= color_index;
			x0_s1    <= {start_x[W-1], start_x};
			y0_s1    <= {start_y[W-1], start_y};
			dx_s1    <= {end_x[W-1], end_x} - {start_x[W-1], start_x};
			dy_s1    <= {end_y[W-1], end_y} - {start_y[W-1], start_y};
		end
	end

	// |dx| vs |dy| per quadrant reduces to the sign of dx+dy or dx-dy
	assign sum  = {dx_s1[W], dx_s1} + {dy_s1[W], dy_s1};
	assign diff = {dx_s1[W], dx_s1} - {dy_s1[W], dy_s1};

	always_comb begin
		case ({dx_s1[W], dy_s1[W]})
			2'b00:   zone = !diff[W+1] ? ezlr_pkg::Zone0 : ezlr_pkg::Zone1;
			2'b10:   zone = (sum[W+1] || sum == '0) ? ezlr_pkg::Zone3 : ezlr_pkg::Zone2;
			2'b11:   zone = (diff[W+1] || diff == '0) ? ezlr_pkg::Zone4 : ezlr_pkg::Zone5;
			default: zone = !sum[W+1] ? ezlr_pkg::Zone7 : ezlr_pkg::Zone6;
		endcase
	end

	assign nx0 = -x0_s1;
	assign ny0 = -y0_s1;
	assign ndx = -dx_s1;
	assign ndy = -dy_s1;

	always_comb begin
		case (zone)
			ezlr_pkg::Zone0: begin
				cmd_a0 = x0_s1; cmd_b0 = y0_s1; ddx_w = dx_s1; ddy_w = dy_s1;
			end
			ezlr_pkg::Zone1: begin
				cmd_a0 = y0_s1; cmd_b0 = x0_s1; ddx_w = dy_s1; ddy_w = dx_s1;
			end
			ezlr_pkg::Zone2: begin
				cmd_a0 = y0_s1; cmd_b0 = nx0; ddx_w = dy_s1; ddy_w = ndx;
			end
			ezlr_pkg::Zone3: begin
				cmd_a0 = nx0; cmd_b0 = y0_s1; ddx_w = ndx; ddy_w = dy_s1;
			end
			ezlr_pkg::Zone4: begin
				cmd_a0 = nx0; cmd_b0 = ny0; ddx_w = ndx; ddy_w = ndy;
			end
			ezlr_pkg::Zone5: begin
				cmd_a0 = ny0; cmd_b0 = nx0; ddx_w = ndy; ddy_w = ndx;
			end
			ezlr_pkg::Zone6: begin
				cmd_a0 = ny0; cmd_b0 = x0_s1; ddx_w = ndy; ddy_w = dx_s1;
			end
			default: begin
				cmd_a0 = x0_s1; cmd_b0 = ny0; ddx_w = dx_s1; ddy_w = ndy;
			end
		endcase
	end

	// in zone 0 both deltas are non-negative and below 2^W
	assign cmd_ddx = ddx_w[W-1:0];
	assign cmd_ddy = ddy_w[W-1:0];

	assign cmd_ctl.op    = op_s1;
	assign cmd_ctl.zone  = zone;
	assign cmd_ctl.color = color_s1;

endmodule

// File: rtl/core/ezlr_back.sv
module ezlr_back #(
	parameter int COORD_BITS = ezlr_pkg::CoordBitsDefault
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_empty,
	output logic                  cmd_rd,
	input  ezlr_pkg::cmd_ctl_t    cmd_ctl,
	input  logic [COORD_BITS:0]   cmd_a0,
	input  logic [COORD_BITS:0]   cmd_b0,
	input  logic [COORD_BITS-1:0] cmd_ddx,
	input  logic [COORD_BITS-1:0] cmd_ddy,
	output logic                  empty,
	input  logic                  pop,
	output logic                  pixel_valid,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [1:0]            pixel_color,
	output logic [2:0]            line_zone,
	output logic                  last_pixel
);

	localparam int W       = COORD_BITS;
	localparam int ResBits = ezlr_pkg::ResCtlBits + 2 * (W + 1);

	logic [W:0]    walk_x_q;
	logic [W:0]    walk_y_q;
	logic [W+2:0]  decision_q;
	logic [W+1:0]  east_q;
	logic [W+1:0]  ne_q;
	logic [W-1:0]  rem_q;
	logic [2:0]    zone_q;
	logic [1:0]    color_q;
	logic          active_q;

	logic          res_full;
	logic          go;
	logic          is_start;
	logic          is_step;

	logic [W+2:0]  dec_init;
	logic [W+1:0]  east_init;
	logic [W+1:0]  ne_init;
	logic [W+2:0]  dec_step;
	logic [W:0]    walk_x_inc;
	logic [W:0]    walk_y_inc;

	ezlr_pkg::res_ctl_t res_ctl;
	logic [W:0]         res_a;
	logic [W:0]         res_b;
	logic [ResBits-1:0] res_wdata;
	logic [ResBits-1:0] res_rdata;
	ezlr_pkg::res_ctl_t out_ctl;
	logic [W:0]         out_a;
	logic [W:0]         out_b;
	logic [W:0]         out_x;
	logic [W:0]         out_y;

	assign go       = !cmd_empty && !res_full;
	assign cmd_rd   = go;
	assign is_start = go && (cmd_ctl.op == ezlr_pkg::OpStart);
	assign is_step  = go && (cmd_ctl.op == ezlr_pkg::OpStep) && active_q;

	assign dec_init  = {2'b00, cmd_ddy, 1'b0} - {3'b000, cmd_ddx};
	assign east_init = {1'b0, cmd_ddy, 1'b0};
	assign ne_init   = {1'b0, cmd_ddy, 1'b0} - {1'b0, cmd_ddx, 1'b0};

	// midpoint update: east when the decision term is negative
	assign dec_step   = decision_q[W+2] ? decision_q + {east_q[W+1], east_q}
	                                    : decision_q + {ne_q[W+1], ne_q};
	assign walk_x_inc = walk_x_q + 1'b1;
	assign walk_y_inc = decision_q[W+2] ? walk_y_q : walk_y_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_x_q   <= '0;
			walk_y_q   <= '0;
			decision_q <= '0;
			east_q     <= '0;
			ne_q       <= '0;
			rem_q      <= '0;
			zone_q     <= ezlr_pkg::Zone0;
			color_q    <= 2'd0;
			active_q   <= 1'b0;
		end else if (is_start) begin
			walk_x_q   <= cmd_a0;
			walk_y_q   <= cmd_b0;
			decision_q <= dec_init;
			east_q     <= east_init;
			ne_q       <= ne_init;
			rem_q      <= cmd_ddx;
			zone_q     <= cmd_ctl.zone;
			color_q    <= cmd_ctl.color;
			active_q   <= (cmd_ddx != '0);
		end else if (is_step) begin
			walk_x_q   <= walk_x_inc;
			walk_y_q   <= walk_y_inc;
			decision_q <= dec_step;
			rem_q      <= rem_q - 1'b1;
			active_q   <= (rem_q != W'(1));
		end
	end

	// result word carries zone-0 coordinates; remap happens on the read side
	always_comb begin
		if (is_start) begin
			res_ctl.valid = 1'b1;
			res_ctl.zone  = cmd_ctl.zone;
			res_ctl.color = cmd_ctl.color;
			res_ctl.last  = (cmd_ddx == '0);
			res_a         = cmd_a0;
			res_b         = cmd_b0;
		end else if (is_step) begin
			res_ctl.valid = 1'b1;
			res_ctl.zone  = zone_q;
			res_ctl.color = color_q;
			res_ctl.last  = (rem_q == W'(1));
			res_a         = walk_x_inc;
			res_b         = walk_y_inc;
		end else begin
			res_ctl.valid = 1'b0;
			res_ctl.zone  = ezlr_pkg::Zone0;
			res_ctl.color = 2'd0;
			res_ctl.last  = 1'b0;
			res_a         = '0;
			res_b         = '0;
		end
	end

	assign res_wdata = {res_ctl, res_a, res_b};

	ezlr_queue #(
		.DATA_BITS(ResBits)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (go),
		.wdata (res_wdata),
		.full  (res_full),
		.rd    (pop),
		.rdata (res_rdata),
		.empty (empty)
	);

	assign {out_ctl, out_a, out_b} = res_rdata;

	always_comb begin
		case (out_ctl.zone)
			ezlr_pkg::Zone0: begin out_x = out_a;  out_y = out_b;  end
			ezlr_pkg::Zone1: begin out_x = out_b;  out_y = out_a;  end
			ezlr_pkg::Zone2: begin out_x = -out_b; out_y = out_a;  end
			ezlr_pkg::Zone3: begin out_x = -out_a; out_y = out_b;  end
			ezlr_pkg::Zone4: begin out_x = -out_a; out_y = -out_b; end
			ezlr_pkg::Zone5: begin out_x = -out_b; out_y = -out_a; end
			ezlr_pkg::Zone6: begin out_x = out_b;  out_y = -out_a; end
			default:         begin out_x = out_a;  out_y = -out_b; end
		endcase
	end

	assign pixel_valid = out_ctl.valid;
	assign pixel_x     = out_x[W-1:0];
	assign pixel_y     = out_y[W-1:0];
	assign pixel_color = out_ctl.color;
	assign line_zone   = out_ctl.zone;
	assign last_pixel  = out_ctl.last;

endmodule

// File: rtl/core/eight_zone_line_rasterizer.sv
// Eight-octant midpoint line rasterizer.
// Input channel (push/full): a word is taken when push is high and full is low.
//   operation = start latches both endpoints and the color and returns the
//   first pixel; operation = step returns the next pixel of the current line.
//   A step with no line in progress returns a word with pixel_valid low and
//   all other fields zero. A start during a line drops the old line.
// Output channel (empty/pop): the oldest result word sits on the pixel ports
//   while empty is low and is taken when pop is high.
// Exactly one result word per input word, in order.
// A result becomes visible once it has passed the classify stage, the command
//   queue and the walker stage into the result queue.
// Throughput: one word per cycle while neither queue is full; the walker updates
//   its decision term, position and remaining count as it writes each result word.
// Two-entry queues sit between classifier and walker and at the output, so
//   either side may stall; a stalled consumer fills the output queue, then the
//   command queue, and then full rises.
// Reset (arst_n low) empties both queues and leaves the walker idle.
module eight_zone_line_rasterizer #(
	parameter int COORD_BITS = ezlr_pkg::CoordBitsDefault
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  operation,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	input  logic [1:0]            color_index,
	output logic                  empty,
	input  logic                  pop,
	output logic                  pixel_valid,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [1:0]            pixel_color,
	output logic [2:0]            line_zone,
	output logic                  last_pixel
);

	localparam int W       = COORD_BITS;
	localparam int CmdBits = ezlr_pkg::CmdCtlBits + 2 * (W + 1) + 2 * W;

	logic                  f_wr;
	logic                  f_full;
	ezlr_pkg::cmd_ctl_t    f_ctl;
	logic [W:0]            f_a0;
	logic [W:0]            f_b0;
	logic [W-1:0]          f_ddx;
	logic [W-1:0]          f_ddy;
	logic [CmdBits-1:0]    q_wdata;
	logic [CmdBits-1:0]    q_rdata;
	logic                  q_empty;
	logic                  q_rd;
	ezlr_pkg::cmd_ctl_t    b_ctl;
	logic [W:0]            b_a0;
	logic [W:0]            b_b0;
	logic [W-1:0]          b_ddx;
	logic [W-1:0]          b_ddy;

	ezlr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.operation  (operation),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.color_index(color_index),
		.cmd_wr     (f_wr),
		.cmd_full   (f_full),
		.cmd_ctl    (f_ctl),
		.cmd_a0     (f_a0),
		.cmd_b0     (f_b0),
		.cmd_ddx    (f_ddx),
		.cmd_ddy    (f_ddy)
	);

	assign q_wdata = {f_ctl, f_a0, f_b0, f_ddx, f_ddy};

	ezlr_queue #(
		.DATA_BITS(CmdBits)
	) u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (f_wr),
		.wdata (q_wdata),
		.full  (f_full),
		.rd    (q_rd),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	assign {b_ctl, b_a0, b_b0, b_ddx, b_ddy} = q_rdata;

	ezlr_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_empty  (q_empty),
		.cmd_rd     (q_rd),
		.cmd_ctl    (b_ctl),
		.cmd_a0     (b_a0),
		.cmd_b0     (b_b0),
		.cmd_ddx    (b_ddx),
		.cmd_ddy    (b_ddy),
		.empty      (empty),
		.pop        (pop),
		.pixel_valid(pixel_valid),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_color(pixel_color),
		.line_zone  (line_zone),
		.last_pixel (last_pixel)
	);

endmodule
